FILE: rtl/c3f_pkg.sv
`default_nettype none

package c3f_pkg;

    localparam int PIX_W       = 8;
    localparam int COEF_W      = 16;
    localparam int NCHAN       = 3;
    localparam int TAPS        = 9;
    localparam int KROWS       = 3;
    localparam int KCOLS       = 3;
    // one product stage, then one stage per tap
    localparam int LANE_STAGES = TAPS + 1;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 11;
    localparam int FW_W        = 12;
    localparam int FH_W        = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    localparam int DEF_MAX_WIDTH      = 2048;
    localparam int DEF_MAX_HEIGHT     = 4096;
    localparam int DEF_COEF_FRAC_BITS = 12;

    localparam logic [FW_W-1:0]       RST_FRAME_WIDTH  = 12'd640;
    localparam logic [FH_W-1:0]       RST_FRAME_HEIGHT = 13'd480;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_OUTER   = 48'h0100_0200_0100;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_MID     = 48'h0200_0400_0200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_MODE,
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT,
        CFG_COEF_TOP,
        CFG_COEF_MID,
        CFG_COEF_BOTTOM
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix_chan0;
        logic [PIX_W-1:0] pix_chan1;
        logic [PIX_W-1:0] pix_chan2;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] res_chan0;
        logic [PIX_W-1:0] res_chan1;
        logic [PIX_W-1:0] res_chan2;
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic             frame_done;
    } res_t;

    typedef struct packed {
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic             frame_done;
    } meta_t;

    typedef struct packed {
        logic [LANE_STAGES-1:0] load;
    } lane_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/c3f_ram.sv
`default_nettype none

module c3f_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/c3f_front.sv
`default_nettype none

module c3f_front #(
    parameter int MAX_WIDTH  = c3f_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3f_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic [c3f_pkg::FW_W-1:0]               frame_width,
    input  wire logic [c3f_pkg::FH_W-1:0]               frame_height,
    input  wire logic                                   pixel_valid,
    output logic                                        pixel_stall,
    input  wire c3f_pkg::pix_in_t                       pixel,
    input  wire logic                                   win_ready,
    output logic                                        win_valid,
    output c3f_pkg::pix_in_t [c3f_pkg::TAPS-1:0]        window,
    output c3f_pkg::meta_t                              win_meta
);

    import c3f_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PIXW = $bits(pix_in_t);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;

    logic          a_valid_reg;
    pix_in_t       a_pix_reg;
    logic [CW-1:0] a_col_reg;
    logic [RW-1:0] a_row_reg;

    logic          b_valid_reg, b_valid_next;
    meta_t         b_meta_reg;
    pix_in_t [TAPS-1:0] window_reg, window_next;

    logic          accept, a_move, b_ready, is_result;
    logic [PIXW-1:0] prev_rdata, prev2_rdata;
    logic [CW-1:0] col_m1;
    logic [RW-1:0] row_m1;

    // clamp the frame size to [3, MAX]
    always_comb
    begin
        if (frame_width < FW_W'(3))
            w_last = CW'(2);
        else if (32'(frame_width) > 32'(MAX_WIDTH))
            w_last = CW'(MAX_WIDTH - 1);
        else
            w_last = CW'(frame_width - FW_W'(1));

        if (frame_height < FH_W'(3))
            h_last = RW'(2);
        else if (32'(frame_height) > 32'(MAX_HEIGHT))
            h_last = RW'(MAX_HEIGHT - 1);
        else
            h_last = RW'(frame_height - FH_W'(1));
    end

    assign b_ready     = !b_valid_reg || win_ready;
    assign a_move      = a_valid_reg && b_ready;
    assign pixel_stall = a_valid_reg && !b_ready;
    assign accept      = pixel_valid && !pixel_stall;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_reg >= w_last)
            begin
                col_next = '0;
                row_next = (row_reg >= h_last) ? '0 : RW'(row_reg + 1'b1);
            end
            else
            begin
                col_next = CW'(col_reg + 1'b1);
            end
        end
    end

    c3f_ram #(
        .WIDTH (PIXW),
        .DEPTH (MAX_WIDTH)
    ) u_line_prev (
        .clk   (clk),
        .we    (a_move),
        .waddr (a_col_reg),
        .wdata (a_pix_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (prev_rdata)
    );

    c3f_ram #(
        .WIDTH (PIXW),
        .DEPTH (MAX_WIDTH)
    ) u_line_prev2 (
        .clk   (clk),
        .we    (a_move),
        .waddr (a_col_reg),
        .wdata (prev_rdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (prev2_rdata)
    );

    assign is_result = (a_row_reg >= RW'(2)) && (a_col_reg >= CW'(2));
    assign col_m1    = CW'(a_col_reg - 1'b1);
    assign row_m1    = RW'(a_row_reg - 1'b1);

    always_comb
    begin
        window_next = window_reg;
        if (a_move)
        begin
            for (int k = 0; k < KROWS; k++)
            begin
                window_next[k*KCOLS]     = window_reg[k*KCOLS + 1];
                window_next[k*KCOLS + 1] = window_reg[k*KCOLS + 2];
            end
            window_next[2] = pix_in_t'(prev2_rdata);
            window_next[5] = pix_in_t'(prev_rdata);
            window_next[8] = a_pix_reg;
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (a_move)
            b_valid_next = is_result;
        else if (win_ready)
            b_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            window_reg  <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= b_valid_next;
            window_reg  <= window_next;
            if (accept)
                a_valid_reg <= 1'b1;
            else if (a_move)
                a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg <= pixel;
            a_col_reg <= col_reg;
            a_row_reg <= row_reg;
        end
        if (a_move)
        begin
            b_meta_reg.center_row <= ROW_W'(row_m1);
            b_meta_reg.center_col <= COL_W'(col_m1);
            b_meta_reg.frame_done <= (a_row_reg == h_last) && (a_col_reg == w_last);
        end
    end

    assign win_valid = b_valid_reg;
    assign window    = window_reg;
    assign win_meta  = b_meta_reg;

endmodule

`default_nettype wire

FILE: rtl/c3f_lane.sv
`default_nettype none

module c3f_lane #(
    parameter int COEF_FRAC_BITS = c3f_pkg::DEF_COEF_FRAC_BITS
) (
    input  wire logic                                                clk,
    input  wire c3f_pkg::lane_ctl_t                                  ctl,
    input  wire logic [c3f_pkg::TAPS-1:0][c3f_pkg::PIX_W-1:0]        pix,
    input  wire logic [c3f_pkg::TAPS-1:0][c3f_pkg::COEF_W-1:0]       taps,
    output logic      [c3f_pkg::PIX_W-1:0]                           res
);

    import c3f_pkg::*;

    // product of an unsigned pixel and a signed tap
    localparam int PW = PIX_W + COEF_W + 1;
    // nine products, scaled down by the fraction bits, plus sign headroom
    localparam int SW = PW + 5 - COEF_FRAC_BITS;
    localparam int TW = SW + COEF_FRAC_BITS + 1;

    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [SW-1:0] acc_t;

    prod_t prod_next [TAPS];
    prod_t q_reg     [LANE_STAGES][TAPS];
    acc_t  sum_reg   [LANE_STAGES];
    acc_t  sum_step  [LANE_STAGES];

    // add one tap at full scale, then truncate toward zero
    function automatic acc_t tap_step(input acc_t s, input prod_t p);
        logic signed [TW-1:0] t;
        logic signed [TW-1:0] q;
        t = (TW'(s) <<< COEF_FRAC_BITS) + TW'(p);
        q = t >>> COEF_FRAC_BITS;
        if (t[TW-1] && (t[COEF_FRAC_BITS-1:0] != '0))
            q = q + TW'(1);
        return SW'(q);
    endfunction

    always_comb
    begin
        for (int j = 0; j < TAPS; j++)
            prod_next[j] = PW'($signed({1'b0, pix[j]})) * PW'($signed(taps[j]));
    end

    always_comb
    begin
        sum_step[0] = '0;
        for (int k = 1; k < LANE_STAGES; k++)
            sum_step[k] = tap_step(sum_reg[k-1], q_reg[k-1][0]);
    end

    // products queue up behind the running sum; each stage consumes the head
    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            for (int j = 0; j < TAPS; j++)
                q_reg[0][j] <= prod_next[j];
            sum_reg[0] <= sum_step[0];
        end
        for (int k = 1; k < LANE_STAGES; k++)
        begin
            if (ctl.load[k])
            begin
                for (int j = 0; j < TAPS - 1; j++)
                    q_reg[k][j] <= q_reg[k-1][j+1];
                q_reg[k][TAPS-1] <= '0;
                sum_reg[k]       <= sum_step[k];
            end
        end
    end

    assign res = sum_reg[LANE_STAGES-1][PIX_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/c3f_merge.sv
`default_nettype none

module c3f_merge (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          color_mode,
    input  wire logic                                          win_valid,
    output logic                                               win_ready,
    input  wire c3f_pkg::meta_t                                win_meta,
    output c3f_pkg::lane_ctl_t                                 lane_ctl,
    input  wire logic [c3f_pkg::NCHAN-1:0][c3f_pkg::PIX_W-1:0] lane_res,
    output logic                                               result_valid,
    input  wire logic                                          result_stall,
    output c3f_pkg::res_t                                      result
);

    import c3f_pkg::*;

    localparam int LAST = LANE_STAGES - 1;

    logic [LANE_STAGES-1:0] s_valid_reg, s_valid_next;
    logic [LANE_STAGES-1:0] s_ready, s_move, load;
    meta_t                  meta_reg [LANE_STAGES];
    logic                   out_valid_reg;
    res_t                   out_reg;
    logic                   o_ready;
    logic                   nxt_ready;

    assign o_ready = !out_valid_reg || !result_stall;

    // a stage moves when the one after it is empty or moving
    always_comb
    begin
        nxt_ready = o_ready;
        for (int k = LAST; k >= 0; k--)
        begin
            s_move[k]  = s_valid_reg[k] && nxt_ready;
            s_ready[k] = !s_valid_reg[k] || nxt_ready;
            nxt_ready  = s_ready[k];
        end
    end

    always_comb
    begin
        load[0] = win_valid && s_ready[0];
        for (int k = 1; k < LANE_STAGES; k++)
            load[k] = s_move[k-1];
    end

    always_comb
    begin
        for (int k = 0; k < LANE_STAGES; k++)
        begin
            if (load[k])
                s_valid_next[k] = 1'b1;
            else if (s_move[k])
                s_valid_next[k] = 1'b0;
            else
                s_valid_next[k] = s_valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            if (s_move[LAST])
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
            meta_reg[0] <= win_meta;
        for (int k = 1; k < LANE_STAGES; k++)
        begin
            if (load[k])
                meta_reg[k] <= meta_reg[k-1];
        end
        // grey mode keeps channel 0 only
        if (s_move[LAST])
        begin
            out_reg.res_chan0  <= lane_res[0];
            out_reg.res_chan1  <= color_mode ? lane_res[1] : '0;
            out_reg.res_chan2  <= color_mode ? lane_res[2] : '0;
            out_reg.center_row <= meta_reg[LAST].center_row;
            out_reg.center_col <= meta_reg[LAST].center_col;
            out_reg.frame_done <= meta_reg[LAST].frame_done;
        end
    end

    assign win_ready     = s_ready[0];
    assign lane_ctl.load = load;
    assign result_valid  = out_valid_reg;
    assign result        = out_reg;

endmodule

`default_nettype wire

FILE: rtl/conv3x3_image_filter_top.sv
// 3x3 convolution filter over a raster-order pixel stream.
//
// Pixel channel: one pixel per transaction (pixel_valid / pixel_stall), rows in order,
// grey in pix_chan0 or RGB in all three channels. Result channel: one transaction
// (result_valid / result_stall) per interior pixel; pixels in the first two rows or
// the first two columns of a frame give none. Each result carries the filtered
// channels (low 8 bits of the sum), the position of the centre pixel and frame_done
// on the last interior pixel of the frame.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while no pixel is in flight.
// Path from an accepted pixel to its result: line store read, window update, product
// stage, nine accumulate stages (one per tap, since the sum is truncated after every
// tap) and the output register. One pixel per cycle is accepted in steady state while
// the result side does not stall; the three channels run in parallel lanes.
// A stall on the result side fills the pipeline bubble by bubble before pixel_stall
// rises, and pixel_stall is never high while result_valid is low.
// Reset clears the row and column counters, the window and all valid bits; the line
// stores need no clearing.
`default_nettype none

module conv3x3_image_filter_top #(
    parameter int MAX_WIDTH      = c3f_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = c3f_pkg::DEF_MAX_HEIGHT,
    parameter int COEF_FRAC_BITS = c3f_pkg::DEF_COEF_FRAC_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pixel_valid,
    output logic                                 pixel_stall,
    input  wire c3f_pkg::pix_in_t                pixel,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output c3f_pkg::res_t                        result,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [c3f_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [c3f_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import c3f_pkg::*;

    logic                  color_mode_reg;
    logic [FW_W-1:0]       frame_width_reg;
    logic [FH_W-1:0]       frame_height_reg;
    logic [CFG_DATA_W-1:0] coef_top_row_reg;
    logic [CFG_DATA_W-1:0] coef_mid_row_reg;
    logic [CFG_DATA_W-1:0] coef_bottom_row_reg;

    logic [CFG_DATA_W-1:0]                 coef_rows [KROWS];
    logic [TAPS-1:0][COEF_W-1:0]           taps;
    pix_in_t [TAPS-1:0]                    window;
    logic [NCHAN-1:0][TAPS-1:0][PIX_W-1:0] lane_pix;
    logic [NCHAN-1:0][PIX_W-1:0]           lane_res;
    logic                                  win_valid, win_ready;
    meta_t                                 win_meta;
    lane_ctl_t                             lane_ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg      <= 1'b0;
            frame_width_reg     <= RST_FRAME_WIDTH;
            frame_height_reg    <= RST_FRAME_HEIGHT;
            coef_top_row_reg    <= RST_COEF_OUTER;
            coef_mid_row_reg    <= RST_COEF_MID;
            coef_bottom_row_reg <= RST_COEF_OUTER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COLOR_MODE:   color_mode_reg      <= cfg_data[0];
                CFG_FRAME_WIDTH:  frame_width_reg     <= cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg    <= cfg_data[FH_W-1:0];
                CFG_COEF_TOP:     coef_top_row_reg    <= cfg_data;
                CFG_COEF_MID:     coef_mid_row_reg    <= cfg_data;
                CFG_COEF_BOTTOM:  coef_bottom_row_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign coef_rows[0] = coef_top_row_reg;
    assign coef_rows[1] = coef_mid_row_reg;
    assign coef_rows[2] = coef_bottom_row_reg;

    // left tap sits in the low bits of each row word
    always_comb
    begin
        for (int r = 0; r < KROWS; r++)
            for (int c = 0; c < KCOLS; c++)
                taps[r*KCOLS + c] = coef_rows[r][c*COEF_W +: COEF_W];
    end

    always_comb
    begin
        for (int j = 0; j < TAPS; j++)
        begin
            lane_pix[0][j] = window[j].pix_chan0;
            lane_pix[1][j] = window[j].pix_chan1;
            lane_pix[2][j] = window[j].pix_chan2;
        end
    end

    c3f_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .win_ready    (win_ready),
        .win_valid    (win_valid),
        .window       (window),
        .win_meta     (win_meta)
    );

    for (genvar ch = 0; ch < NCHAN; ch++)
    begin : g_lane
        c3f_lane #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .ctl  (lane_ctl),
            .pix  (lane_pix[ch]),
            .taps (taps),
            .res  (lane_res[ch])
        );
    end

    c3f_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .color_mode   (color_mode_reg),
        .win_valid    (win_valid),
        .win_ready    (win_ready),
        .win_meta     (win_meta),
        .lane_ctl     (lane_ctl),
        .lane_res     (lane_res),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: rtl/c3f_checker.sv
`default_nettype none

module c3f_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            pixel_stall,
    input wire logic                            result_valid,
    input wire logic                            result_stall,
    input wire c3f_pkg::res_t                   result,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready
);

    import c3f_pkg::*;

    // hold a stalled result transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result payload changed while stalled");

    // with the output register empty nothing downstream can block the pixel side
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !pixel_stall)
        else $error("pixel side stalled with no result pending");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.center_row != '0) && (result.center_col != '0))
        else $error("result centred on a border pixel");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind conv3x3_image_filter_top c3f_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire

FILE: verif/tb_conv3x3_image_filter_top.sv
module tb_conv3x3_image_filter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import c3f_pkg::*;

    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PIXELS  = 800;
    localparam int FILL_WIDTH     = 12;

    typedef struct packed {
        cfg_idx_t                idx;
        logic [CFG_DATA_W-1:0]   data;
    } reg_write_t;

    typedef enum bit {STEP_PIXEL, STEP_REG} step_kind_t;

    typedef struct {
        step_kind_t  kind;
        pix_in_t     px;
        bit          typed;
        res_t        want;
        reg_write_t  wr;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    pixel_valid;
    logic                    pixel_stall;
    pix_in_t                 pixel;
    logic                    result_valid;
    logic                    result_stall;
    res_t                    result;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // filter state as seen from the pixel stream
    logic                    m_mode;
    logic [FW_W-1:0]         m_width;
    logic [FH_W-1:0]         m_height;
    logic [CFG_DATA_W-1:0]   m_coef [KROWS];
    logic [23:0]             ln_above  [DEF_MAX_WIDTH];
    logic [23:0]             ln_above2 [DEF_MAX_WIDTH];
    logic [23:0]             win [TAPS];
    int                      row_pos;
    int                      col_pos;

    res_t        filtered_due [$];
    reg_write_t  reg_backlog [$];
    stim_row_t   plan [$];

    int idle_pct;
    int mismatches;
    int pixels_sent;
    int results_seen;
    int reg_writes;
    int quiet_cycles;

    conv3x3_image_filter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void filter_reset();
        m_mode   = 1'b0;
        m_width  = RST_FRAME_WIDTH;
        m_height = RST_FRAME_HEIGHT;
        m_coef[0] = RST_COEF_OUTER;
        m_coef[1] = RST_COEF_MID;
        m_coef[2] = RST_COEF_OUTER;
        for (int i = 0; i < DEF_MAX_WIDTH; i++)
        begin
            ln_above[i]  = '0;
            ln_above2[i] = '0;
        end
        for (int i = 0; i < TAPS; i++)
            win[i] = '0;
        row_pos = 0;
        col_pos = 0;
    endfunction

    function automatic void apply_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_COLOR_MODE:   m_mode    = data[0];
            CFG_FRAME_WIDTH:  m_width   = data[FW_W-1:0];
            CFG_FRAME_HEIGHT: m_height  = data[FH_W-1:0];
            CFG_COEF_TOP:     m_coef[0] = data;
            CFG_COEF_MID:     m_coef[1] = data;
            CFG_COEF_BOTTOM:  m_coef[2] = data;
            default: ;
        endcase
    endfunction

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // truncate toward zero after every tap, as a float product added into an int would
    function automatic logic [PIX_W-1:0] conv_lane(input int ch);
        longint acc;
        longint prod;
        longint scale;
        logic [COEF_W-1:0] raw;
        int r;
        int c;
        acc = 0;
        scale = longint'(1) << DEF_COEF_FRAC_BITS;
        for (r = 0; r < KROWS; r++)
        begin
            for (c = 0; c < KCOLS; c++)
            begin
                raw  = m_coef[r][COEF_W*c +: COEF_W];
                prod = longint'(win[r*KCOLS + c][PIX_W*ch +: PIX_W]) * longint'($signed(raw));
                acc  = (acc * scale + prod) / scale;
            end
        end
        return acc[PIX_W-1:0];
    endfunction

    function automatic bit filter_pixel(input pix_in_t p, output res_t r);
        int w;
        int h;
        int idx;
        logic [23:0] above;
        logic [23:0] above2;
        bit hit;
        w = clamp_dim(int'(m_width), DEF_MAX_WIDTH);
        h = clamp_dim(int'(m_height), DEF_MAX_HEIGHT);
        idx = col_pos % DEF_MAX_WIDTH;
        above  = ln_above[idx];
        above2 = ln_above2[idx];
        for (int k = 0; k < KROWS; k++)
        begin
            win[k*3]     = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
        end
        win[2] = above2;
        win[5] = above;
        win[8] = {p.pix_chan2, p.pix_chan1, p.pix_chan0};
        ln_above2[idx] = above;
        ln_above[idx]  = win[8];
        r = '0;
        hit = 1'b0;
        if (row_pos >= 2 && col_pos >= 2)
        begin
            hit = 1'b1;
            r.res_chan0  = conv_lane(0);
            r.res_chan1  = m_mode ? conv_lane(1) : '0;
            r.res_chan2  = m_mode ? conv_lane(2) : '0;
            r.center_row = ROW_W'(row_pos - 1);
            r.center_col = COL_W'(col_pos - 1);
            r.frame_done = (row_pos == h - 1) && (col_pos == w - 1);
        end
        // counters keep going across size changes and wrap at the next advance
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
        return hit;
    endfunction

    function automatic logic [COEF_W-1:0] pick_tap();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'h1000;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_taps();
        return {pick_tap(), pick_tap(), pick_tap()};
    endfunction

    // rows never grow past the filled part of the line stores
    function automatic logic [CFG_DATA_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: return CFG_DATA_W'($urandom_range(0, 2));
            default: return CFG_DATA_W'($urandom_range(3, FILL_WIDTH));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height();
        case ($urandom_range(0, 19))
            0: return CFG_DATA_W'($urandom_range(0, 2));
            1: return CFG_DATA_W'($urandom_range(4096, 8191));
            default: return CFG_DATA_W'($urandom_range(3, 8));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic void add_pix(input pix_in_t px, input bit typed, input res_t want);
        stim_row_t row;
        row.kind  = STEP_PIXEL;
        row.px    = px;
        row.typed = typed;
        row.want  = want;
        row.wr    = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.kind    = STEP_REG;
        row.px      = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        row.wr.idx  = idx;
        row.wr.data = data;
        plan.push_back(row);
    endfunction

    task automatic push_pixel(input pix_in_t p, input bit typed, input res_t want);
        res_t predicted;
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 14);
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        do @(posedge clk); while (pixel_stall);
        if (filter_pixel(p, predicted))
            filtered_due.push_back(typed ? want : predicted);
        pixels_sent++;
    endtask

    // drop valid, let every expected result out, then let trailing border pixels finish
    task automatic settle();
        pixel_valid <= 1'b0;
        while (filtered_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic flush_regs();
        reg_write_t wr;
        while (reg_backlog.size() != 0)
        begin
            wr = reg_backlog.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= wr.idx;
            cfg_data  <= wr.data;
            do @(posedge clk); while (!cfg_ready);
            apply_reg(wr.idx, wr.data);
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        reg_write_t wr;
        wr.idx  = idx;
        wr.data = data;
        reg_backlog.push_back(wr);
    endtask

    task automatic compare_result(input res_t want, input res_t got);
        if (got.res_chan0 !== want.res_chan0)
        begin
            $error("res_chan0: expected %0d, got %0d", want.res_chan0, got.res_chan0);
            mismatches++;
        end
        if (got.res_chan1 !== want.res_chan1)
        begin
            $error("res_chan1: expected %0d, got %0d", want.res_chan1, got.res_chan1);
            mismatches++;
        end
        if (got.res_chan2 !== want.res_chan2)
        begin
            $error("res_chan2: expected %0d, got %0d", want.res_chan2, got.res_chan2);
            mismatches++;
        end
        if (got.center_row !== want.center_row)
        begin
            $error("center_row: expected %0d, got %0d", want.center_row, got.center_row);
            mismatches++;
        end
        if (got.center_col !== want.center_col)
        begin
            $error("center_col: expected %0d, got %0d", want.center_col, got.center_col);
            mismatches++;
        end
        if (got.frame_done !== want.frame_done)
        begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (filtered_due.size() == 0)
            begin
                $error("result transaction with none expected: row %0d col %0d",
                       result.center_row, result.center_col);
                mismatches++;
            end
            else
                compare_result(filtered_due.pop_front(), result);
        end
    end

    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : result_backpressure
        int stall_left;
        stall_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                stall_left = $urandom_range(1, 14);
            result_stall <= (stall_left > 0);
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        pix_in_t px;
        int n;
        int rand_sent;
        pixel_valid <= 1'b0;
        pixel       <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_COLOR_MODE;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        idle_pct     = 0;
        mismatches   = 0;
        pixels_sent  = 0;
        results_seen = 0;
        reg_writes   = 0;
        quiet_cycles = 0;
        filter_reset();

        // 3x3 frames: one interior pixel each, so every result also closes the frame
        add_reg(CFG_FRAME_WIDTH, 48'd0);
        add_reg(CFG_FRAME_HEIGHT, 48'd3);
        for (int i = 0; i < 9; i++)
            add_pix({8'h00, 8'hff, 8'hff}, i == 8, {8'd0, 8'd0, 8'd0, 12'd1, 11'd1, 1'b1});
        for (int i = 0; i < 9; i++)
            add_pix({8'hff, 8'hff, 8'hff}, i == 8, {8'd247, 8'd0, 8'd0, 12'd1, 11'd1, 1'b1});
        add_reg(CFG_COEF_MID, {16'h7fff, 16'h8000, 16'hf000});
        for (int i = 0; i < 9; i++)
        begin
            // switch to RGB while the frame is half in
            if (i == 5)
                add_reg(CFG_COLOR_MODE, 48'd1);
            add_pix({PIX_W'(i * 29 + 1), PIX_W'(255 - i * 31), PIX_W'((i * 57) ^ 8'h5a)},
                    1'b0, '0);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 20;
        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == STEP_REG)
                reg_backlog.push_back(row.wr);
            else
            begin
                if (reg_backlog.size() != 0)
                begin
                    settle();
                    flush_regs();
                end
                push_pixel(row.px, row.typed, row.want);
            end
        end

        // one full frame at the widest row the random part uses fills both line
        // stores across it, so later size changes never reach an unwritten entry
        queue_reg(CFG_COLOR_MODE, 48'd1);
        queue_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(FILL_WIDTH));
        queue_reg(CFG_FRAME_HEIGHT, 48'd3);
        queue_reg(CFG_COEF_TOP, pick_taps());
        queue_reg(CFG_COEF_MID, pick_taps());
        queue_reg(CFG_COEF_BOTTOM, pick_taps());
        settle();
        flush_regs();
        idle_pct = 10;
        repeat (3 * FILL_WIDTH)
        begin
            px = {pick_chan(), pick_chan(), pick_chan()};
            push_pixel(px, 1'b0, '0);
        end

        // phases end wherever they fall, so writes land mid-row and mid-frame
        rand_sent = 0;
        while (rand_sent < RANDOM_PIXELS)
        begin
            if (rand_sent >= RANDOM_PIXELS * 4 / 5)
                idle_pct = 0;
            else
            begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 5;
                    2: idle_pct = 15;
                    default: idle_pct = 35;
                endcase
            end
            if ($urandom_range(0, 1))
                queue_reg(CFG_COLOR_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
                queue_reg(CFG_FRAME_WIDTH, pick_width());
            if ($urandom_range(0, 1))
                queue_reg(CFG_FRAME_HEIGHT, pick_height());
            if ($urandom_range(0, 1))
                queue_reg(CFG_COEF_TOP, pick_taps());
            if ($urandom_range(0, 1))
                queue_reg(CFG_COEF_MID, pick_taps());
            if ($urandom_range(0, 1))
                queue_reg(CFG_COEF_BOTTOM, pick_taps());
            if (reg_backlog.size() != 0)
            begin
                settle();
                flush_regs();
            end
            n = $urandom_range(20, 140);
            repeat (n)
            begin
                px = {pick_chan(), pick_chan(), pick_chan()};
                push_pixel(px, 1'b0, '0);
            end
            rand_sent += n;
        end

        settle();
        $display("Sent %0d pixels, compared %0d filtered pixels, made %0d register writes",
                 pixels_sent, results_seen, reg_writes);
        $display("Grey and RGB frames from 3 to %0d wide, sizes and mode changed mid-frame",
                 FILL_WIDTH);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
